// ===== src/bspf_pkg.sv =====
package bspf_pkg;

  // Register reset values.
  localparam logic [7:0] PREAMBLE_RST = 8'd170;
  localparam logic [7:0] END_RST      = 8'd153;
  localparam logic [7:0] ESCAPE_RST   = 8'd85;
  localparam logic [7:0] MASK_RST     = 8'd32;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_PREAMBLE = 2'd0,
    REG_END      = 2'd1,
    REG_ESCAPE   = 2'd2,
    REG_MASK     = 2'd3
  } cfg_reg_t;

  // Tokens of a frame in line order; each token is one byte, possibly escaped.
  typedef enum logic [2:0] {
    TOK_PRE    = 3'd0,
    TOK_LEN    = 3'd1,
    TOK_DATA   = 3'd2,
    TOK_CRC_LO = 3'd3,
    TOK_CRC_HI = 3'd4,
    TOK_END    = 3'd5
  } tok_t;

  // Bit positions inside the escape flag vector.
  localparam int ESC_LEN    = 0;
  localparam int ESC_DATA   = 1;
  localparam int ESC_CRC_LO = 2;
  localparam int ESC_CRC_HI = 3;

  typedef struct packed {
    logic [7:0] preamble;
    logic [7:0] end_byte;
    logic [7:0] escape;
    logic [7:0] mask;
  } cfg_t;

  // Everything the serializer needs to emit the results of one input item.
  typedef struct packed {
    tok_t        first;
    logic        tail;
    logic [7:0]  len;
    logic [7:0]  data;
    logic [15:0] crc;
    logic [3:0]  esc;
  } frame_t;

  function automatic logic needs_esc(input logic [7:0] b, input cfg_t c);
    needs_esc = (b == c.preamble) || (b == c.end_byte) || (b == c.escape);
  endfunction

endpackage

// ===== src/bspf_ser.sv =====
module bspf_ser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  bspf_pkg::frame_t  frame,
  input  bspf_pkg::cfg_t    cfg,
  output logic              ready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tuser,
  output logic              out_tlast
);

  logic             busy_r, busy_nxt;
  bspf_pkg::frame_t fr_r, fr_nxt;
  bspf_pkg::tok_t   idx_r, idx_nxt;
  logic             half_r, half_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_data_r, out_data_nxt;
  logic             out_done_r, out_done_nxt;
  logic             out_last_r, out_last_nxt;

  logic [7:0] tok_val;
  logic       tok_esc;
  logic [7:0] emit_byte;
  logic       tok_done;
  logic       last_tok;
  logic       step;

  always_comb begin
    tok_val = cfg.end_byte;
    tok_esc = 1'b0;
    case (idx_r)
      bspf_pkg::TOK_PRE: begin
        tok_val = cfg.preamble;
      end
      bspf_pkg::TOK_LEN: begin
        tok_val = fr_r.len;
        tok_esc = fr_r.esc[bspf_pkg::ESC_LEN];
      end
      bspf_pkg::TOK_DATA: begin
        tok_val = fr_r.data;
        tok_esc = fr_r.esc[bspf_pkg::ESC_DATA];
      end
      bspf_pkg::TOK_CRC_LO: begin
        tok_val = fr_r.crc[7:0];
        tok_esc = fr_r.esc[bspf_pkg::ESC_CRC_LO];
      end
      bspf_pkg::TOK_CRC_HI: begin
        tok_val = fr_r.crc[15:8];
        tok_esc = fr_r.esc[bspf_pkg::ESC_CRC_HI];
      end
      default: begin
        tok_val = cfg.end_byte;
        tok_esc = 1'b0;
      end
    endcase
  end

  // An escaped token takes two line bytes: the escape value, then the masked value.
  assign emit_byte = !tok_esc ? tok_val : (half_r ? (tok_val ^ cfg.mask) : cfg.escape);
  assign tok_done  = !tok_esc || half_r;
  assign last_tok  = fr_r.tail ? (idx_r == bspf_pkg::TOK_END) : (idx_r == bspf_pkg::TOK_DATA);
  assign step      = busy_r && (!out_valid_r || out_tready);
  assign ready     = !busy_r || (step && tok_done && last_tok);

  always_comb begin
    busy_nxt      = busy_r;
    fr_nxt        = fr_r;
    idx_nxt       = idx_r;
    half_nxt      = half_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_done_nxt  = out_done_r;
    out_last_nxt  = out_last_r;

    if (step) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_byte;
      out_done_nxt  = (idx_r == bspf_pkg::TOK_END);
      out_last_nxt  = tok_done && last_tok;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (load) begin
      busy_nxt = 1'b1;
      fr_nxt   = frame;
      idx_nxt  = frame.first;
      half_nxt = 1'b0;
    end else if (step) begin
      if (tok_done) begin
        half_nxt = 1'b0;
        if (last_tok) begin
          busy_nxt = 1'b0;
        end else begin
          idx_nxt = bspf_pkg::tok_t'(idx_r + 3'd1);
        end
      end else begin
        half_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= bspf_pkg::TOK_PRE;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      half_r      <= half_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fr_r       <= fr_nxt;
    out_data_r <= out_data_nxt;
    out_done_r <= out_done_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_done_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== src/byte_stuffed_packet_framer_core.sv =====
// Channel  Direction  Handshake              Contents
// in_      slave      in_tvalid/in_tready    one payload byte, start flag, length, CRC
// out_     master     out_tvalid/out_tready  one line byte, end marker flag, last flag
// cfg_     slave      cfg_valid/cfg_ready    register index and 8-bit write data
//
// An accepted item sits in the input register, is decoded into a frame descriptor
// and loaded into the serializer, whose output register then holds its first line byte.
// One line byte goes out per cycle while the output is not stalled, and an item causes
// 1 to 10 line bytes; a dropped item causes none and does not wait for the serializer.
// A stalled output holds its byte and stops the serializer, and then the input.
// Reset is synchronous on rst_n and clears all handshake and packet state.
module byte_stuffed_packet_framer_core (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] payload_byte, [15:8] packet_length, [31:16] packet_crc
  input  logic        in_tuser,   // [0] starts_packet

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] line_byte
  output logic        out_tuser,  // [0] frame_done
  output logic        out_tlast,  // last_of_run

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // Configuration registers.
  bspf_pkg::cfg_t cfg_r, cfg_nxt;

  // Input register.
  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  in_data_r;
  logic        in_start_r;
  logic [7:0]  in_len_r;
  logic [15:0] in_crc_r;

  // Packet state.
  logic        open_r, open_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [15:0] crc_r, crc_nxt;

  logic             accept;
  logic             advance;
  logic             emit;
  logic             tail;
  logic [7:0]       rem_dec;
  logic [15:0]      crc_use;
  logic             ser_ready;
  bspf_pkg::frame_t frame;

  // Registers are always writable; the user must change them only while the block is idle, which it does not enforce.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (bspf_pkg::cfg_reg_t'(cfg_index))
        bspf_pkg::REG_PREAMBLE: cfg_nxt.preamble = cfg_data;
        bspf_pkg::REG_END:      cfg_nxt.end_byte = cfg_data;
        bspf_pkg::REG_ESCAPE:   cfg_nxt.escape   = cfg_data;
        bspf_pkg::REG_MASK:     cfg_nxt.mask     = cfg_data;
        default:                cfg_nxt          = cfg_r;
      endcase
    end
  end

  // A start item with zero length, or a plain byte outside a packet, emits nothing.
  // Such items leave the input register without waiting for the serializer.
  assign emit    = in_start_r ? (in_len_r != 8'd0) : open_r;
  assign rem_dec = (in_start_r ? in_len_r : rem_r) - 8'd1;
  assign tail    = emit && (rem_dec == 8'd0);
  assign crc_use = in_start_r ? in_crc_r : crc_r;
  assign advance = in_valid_r && (ser_ready || !emit);
  assign accept  = in_tvalid && in_tready;
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    frame.first = in_start_r ? bspf_pkg::TOK_PRE : bspf_pkg::TOK_DATA;
    frame.tail  = tail;
    frame.len   = in_len_r;
    frame.data  = in_data_r;
    frame.crc   = crc_use;
    frame.esc   = '0;
    frame.esc[bspf_pkg::ESC_LEN]    = bspf_pkg::needs_esc(in_len_r, cfg_r);
    frame.esc[bspf_pkg::ESC_DATA]   = bspf_pkg::needs_esc(in_data_r, cfg_r);
    frame.esc[bspf_pkg::ESC_CRC_LO] = bspf_pkg::needs_esc(crc_use[7:0], cfg_r);
    frame.esc[bspf_pkg::ESC_CRC_HI] = bspf_pkg::needs_esc(crc_use[15:8], cfg_r);
  end

  // Packet state moves when an item leaves the input register. A start item always
  // abandons any open frame; the packet closes after its last payload byte.
  always_comb begin
    in_valid_nxt = in_valid_r;
    open_nxt     = open_r;
    rem_nxt      = rem_r;
    crc_nxt      = crc_r;
    if (advance) begin
      in_valid_nxt = 1'b0;
      open_nxt     = emit && !tail;
      rem_nxt      = (emit && !tail) ? rem_dec : 8'd0;
      if (in_start_r && (in_len_r != 8'd0)) begin
        crc_nxt = in_crc_r;
      end
    end
    if (accept) begin
      in_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preamble <= bspf_pkg::PREAMBLE_RST;
      cfg_r.end_byte <= bspf_pkg::END_RST;
      cfg_r.escape   <= bspf_pkg::ESCAPE_RST;
      cfg_r.mask     <= bspf_pkg::MASK_RST;
      in_valid_r     <= 1'b0;
      open_r         <= 1'b0;
      rem_r          <= 8'd0;
      crc_r          <= 16'd0;
    end else begin
      cfg_r      <= cfg_nxt;
      in_valid_r <= in_valid_nxt;
      open_r     <= open_nxt;
      rem_r      <= rem_nxt;
      crc_r      <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_data_r  <= in_tdata[7:0];
      in_len_r   <= in_tdata[15:8];
      in_crc_r   <= in_tdata[31:16];
      in_start_r <= in_tuser;
    end
  end

  bspf_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && emit),
    .frame      (frame),
    .cfg        (cfg_r),
    .ready      (ser_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== src/bspf_chk.sv =====
module bspf_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // The end marker is always the final byte caused by its input item.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("end marker not flagged as last");

  // A stalled byte holds with its flags.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output changed");

endmodule

bind byte_stuffed_packet_framer_core bspf_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
